/* rtl/ecdp_pkg.sv */
// Shared types and constants of the EtherCAT datagram parser.
`timescale 1ns / 1ps

package ecdp_pkg;

   // Frame size bound used as the default of the top-level parameter
   localparam int MAX_FRAME_BYTES_DEFAULT = 4096;

   // Depth of the job queue between front and back end
   localparam int JOB_DEPTH = 4;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_ETHERTYPE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_TYPE = 1'b1;

   localparam logic [15:0] ETHERTYPE_RESET  = 16'h88A4;
   localparam logic [3:0]  FRAME_TYPE_RESET = 4'h1;

   // Byte positions of the Ethernet and EtherCAT frame headers
   localparam int POS_ETYPE_HI   = 12;
   localparam int POS_ETYPE_LO   = 13;
   localparam int POS_ECAT_LO    = 14;
   localparam int POS_ECAT_HI    = 15;
   localparam int PAYLOAD_START  = 16;
   localparam int DG_MIN_BYTES   = 12;   // header plus working counter
   localparam int DG_LEN_TAIL    = 5;    // non-data bytes from the length word's high byte on

   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_DESC   = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_SHORT         = 3'd1,
      ST_BAD_ETHERTYPE = 3'd2,
      ST_BAD_TYPE      = 3'd3,
      ST_OVERRUN       = 3'd4
   } status_type;

   // Work for the back end produced by one request byte
   typedef struct packed {
      logic        has_item;      // data byte or descriptor
      logic        item_is_desc;
      logic [7:0]  payload_byte;
      logic [7:0]  command;
      logic [7:0]  datagram_index;
      logic [31:0] slave_address;
      logic [10:0] data_length;
      logic        more_follows;
      logic [15:0] working_counter;
      logic        has_status;    // frame ended on this byte
      status_type  frame_status;
      logic [7:0]  datagram_count;
   } job_type;

   // One result item
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
      logic [7:0]  command;
      logic [7:0]  datagram_index;
      logic [31:0] slave_address;
      logic [10:0] data_length;
      logic        more_follows;
      logic [15:0] working_counter;
      status_type  frame_status;
      logic [7:0]  datagram_count;
      logic        last_of_run;
   } result_type;

endpackage

/* rtl/ecdp_if.sv */
// Request and response channel interfaces of the EtherCAT datagram parser.
`timescale 1ns / 1ps

interface ecdp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, output frame_byte, output frame_end, input ready);
   modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface ecdp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  payload_byte;
   logic [7:0]  command;
   logic [7:0]  datagram_index;
   logic [31:0] slave_address;
   logic [10:0] data_length;
   logic        more_follows;
   logic [15:0] working_counter;
   logic [2:0]  frame_status;
   logic [7:0]  datagram_count;
   logic        last_of_run;

   modport source (output valid, output kind, output payload_byte, output command,
                   output datagram_index, output slave_address, output data_length,
                   output more_follows, output working_counter, output frame_status,
                   output datagram_count, output last_of_run, input ready);
   modport sink   (input valid, input kind, input payload_byte, input command,
                   input datagram_index, input slave_address, input data_length,
                   input more_follows, input working_counter, input frame_status,
                   input datagram_count, input last_of_run, output ready);
endinterface

/* rtl/ecdp_front.sv */
// Front end: byte-wise frame parser that turns data, descriptor and frame-end bytes into back-end jobs.
`timescale 1ns / 1ps

module ecdp_front #(
   parameter int MAX_FRAME_BYTES = ecdp_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   ecdp_req_if.sink                         req_chan,
   input  logic                             csr_write_enable,
   input  logic [ecdp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ecdp_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                             queue_full,
   output logic                             push,
   output ecdp_pkg::job_type                push_job
);
   import ecdp_pkg::*;

   localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int SUM_W = $clog2(MAX_FRAME_BYTES + 2048 + PAYLOAD_START + 1);

   typedef enum logic [4:0] {
      PH_ETH  = 5'b00001,
      PH_DGH  = 5'b00010,
      PH_DATA = 5'b00100,
      PH_WKC  = 5'b01000,
      PH_DONE = 5'b10000
   } phase_type;

   logic [15:0]      ethertype_ff;
   logic [3:0]       frame_type_ff;

   logic [POS_W-1:0] pos_ff, pos_in;
   phase_type        phase_ff, phase_in;
   logic [7:0]       hbyte_ff, hbyte_in;       // first byte of a split header word
   logic [POS_W-1:0] pend_ff, pend_in;         // payload end
   logic [63:0]      dgh_ff, dgh_in;           // datagram header bytes 0..7
   logic [10:0]      remain_ff, remain_in;
   logic [7:0]       wkc_lo_ff, wkc_lo_in;
   logic [7:0]       count_ff, count_in;
   status_type       status_ff, status_in;
   logic [3:0]       sub_ff, sub_in;

   logic             accept;
   logic [7:0]       b;
   logic [SUM_W-1:0] pos_ext, pend_ext, end_calc, dg_end;
   logic [10:0]      dlen;
   status_type       final_status;
   job_type          job;

   assign req_chan.ready = !queue_full;
   assign accept = req_chan.valid && req_chan.ready;
   assign b      = req_chan.frame_byte;

   assign pos_ext  = SUM_W'(pos_ff);
   assign pend_ext = SUM_W'(pend_ff);
   assign dlen     = {b[2:0], dgh_ff[55:48]};
   assign dg_end   = pos_ext + SUM_W'(DG_LEN_TAIL) + SUM_W'(dlen);
   assign end_calc = SUM_W'(PAYLOAD_START) + SUM_W'({b[2:0], hbyte_ff});

   // Parse step
   always_comb begin
      pos_in       = pos_ff;
      phase_in     = phase_ff;
      hbyte_in     = hbyte_ff;
      pend_in      = pend_ff;
      dgh_in       = dgh_ff;
      remain_in    = remain_ff;
      wkc_lo_in    = wkc_lo_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      sub_in       = sub_ff;
      final_status = ST_OK;
      job          = '0;

      case (phase_ff)
         PH_ETH: begin
            if (pos_ff == POS_W'(POS_ETYPE_HI)) begin
               hbyte_in = b;
            end else if (pos_ff == POS_W'(POS_ETYPE_LO)) begin
               if ({hbyte_ff, b} != ethertype_ff) begin
                  status_in = ST_BAD_ETHERTYPE;
                  phase_in  = PH_DONE;
               end
            end else if (pos_ff == POS_W'(POS_ECAT_LO)) begin
               hbyte_in = b;
            end else if (pos_ff == POS_W'(POS_ECAT_HI)) begin
               if (b[7:4] != frame_type_ff) begin
                  status_in = ST_BAD_TYPE;
                  phase_in  = PH_DONE;
               end else begin
                  if (end_calc > SUM_W'(MAX_FRAME_BYTES)) pend_in = POS_W'(MAX_FRAME_BYTES);
                  else pend_in = end_calc[POS_W-1:0];
                  phase_in = PH_DGH;
                  sub_in   = '0;
               end
            end
         end
         PH_DGH: begin
            if (sub_ff == 4'd0 && pos_ext >= pend_ext) begin
               // clean end of the walk
               phase_in = PH_DONE;
            end else if (sub_ff == 4'd0 &&
                         pos_ext + SUM_W'(DG_MIN_BYTES) > pend_ext) begin
               status_in = ST_OVERRUN;
               phase_in  = PH_DONE;
            end else begin
               if (sub_ff < 4'd8) dgh_in[8*sub_ff[2:0] +: 8] = b;
               sub_in = sub_ff + 4'd1;
               if (sub_ff == 4'd7 && dg_end > pend_ext) begin
                  status_in = ST_OVERRUN;
                  phase_in  = PH_DONE;
               end
               if (sub_ff == 4'd9) begin
                  remain_in = dgh_ff[58:48];
                  sub_in    = '0;
                  phase_in  = (dgh_ff[58:48] != 11'd0) ? PH_DATA : PH_WKC;
               end
            end
         end
         PH_DATA: begin
            job.has_item     = 1'b1;
            job.payload_byte = b;
            remain_in        = remain_ff - 11'd1;
            if (remain_ff == 11'd1) begin
               phase_in = PH_WKC;
               sub_in   = '0;
            end
         end
         PH_WKC: begin
            if (sub_ff == 4'd0) begin
               wkc_lo_in = b;
               sub_in    = 4'd1;
            end else begin
               if (count_ff != 8'hFF) count_in = count_ff + 8'd1;
               job.has_item        = 1'b1;
               job.item_is_desc    = 1'b1;
               job.command         = dgh_ff[7:0];
               job.datagram_index  = dgh_ff[15:8];
               job.slave_address   = dgh_ff[47:16];
               job.data_length     = dgh_ff[58:48];
               job.more_follows    = dgh_ff[63];
               job.working_counter = {b, wkc_lo_ff};
               phase_in            = PH_DGH;
               sub_in              = '0;
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      if (pos_ff < POS_W'(MAX_FRAME_BYTES)) pos_in = pos_ff + POS_W'(1);

      job.datagram_count = count_in;

      // Frame end: status result, then per-frame state back to reset
      if (req_chan.frame_end) begin
         final_status = status_in;
         if (pos_ff < POS_W'(POS_ECAT_HI)) begin
            final_status = ST_SHORT;
         end else if (status_in == ST_OK &&
                      (phase_in == PH_DATA || phase_in == PH_WKC ||
                       (phase_in == PH_DGH && sub_in != 4'd0))) begin
            final_status = ST_OVERRUN;
         end
         job.has_status   = 1'b1;
         job.frame_status = final_status;
         pos_in    = '0;
         phase_in  = PH_ETH;
         hbyte_in  = '0;
         pend_in   = '0;
         dgh_in    = '0;
         remain_in = '0;
         wkc_lo_in = '0;
         count_in  = '0;
         status_in = ST_OK;
         sub_in    = '0;
      end
   end

   assign push     = accept && (job.has_item || job.has_status);
   assign push_job = job;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ethertype_ff  <= ETHERTYPE_RESET;
         frame_type_ff <= FRAME_TYPE_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_ETHERTYPE) ethertype_ff <= csr_write_data;
         if (csr_index == CSR_FRAME_TYPE) frame_type_ff <= csr_write_data[3:0];
      end
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         phase_ff  <= PH_ETH;
         pend_ff   <= '0;
         remain_ff <= '0;
         count_ff  <= '0;
         status_ff <= ST_OK;
         sub_ff    <= '0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         pend_ff   <= pend_in;
         remain_ff <= remain_in;
         count_ff  <= count_in;
         status_ff <= status_in;
         sub_ff    <= sub_in;
      end
   end

   // Header collection registers
   always_ff @(posedge clock) begin
      if (accept) begin
         hbyte_ff  <= hbyte_in;
         dgh_ff    <= dgh_in;
         wkc_lo_ff <= wkc_lo_in;
      end
   end

   // A frame end always leaves the parser at the start of a new frame
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.frame_end) |=>
         (phase_ff == PH_ETH && pos_ff == '0 && count_ff == 8'd0))
      else $error("parser state not cleared after frame end");

   // Descriptor count only ever comes from the working-counter phase
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (accept && count_in != count_ff && !req_chan.frame_end) |->
         (phase_ff == PH_WKC && job.item_is_desc))
      else $error("datagram count changed outside descriptor");

endmodule

/* rtl/ecdp_queue.sv */
// Job queue between parser front end and result back end.
`timescale 1ns / 1ps

module ecdp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ecdp_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output ecdp_pkg::job_type head_job
);
   import ecdp_pkg::*;

   localparam int PTR_W = $clog2(JOB_DEPTH);
   localparam int CNT_W = $clog2(JOB_DEPTH + 1);

   job_type          slot_ff [JOB_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full       = (cnt_ff == CNT_W'(JOB_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_job   = slot_ff[rd_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_in  = push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + CNT_W'(1);
      else if (!push && pop) cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_job;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("job queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("job queue read while empty");

endmodule

/* rtl/ecdp_back.sv */
// Back end: expands queued jobs into result items behind an output register.
`timescale 1ns / 1ps

module ecdp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  ecdp_pkg::job_type head_job,
   output logic              pop,
   ecdp_rsp_if.source        rsp_chan
);
   import ecdp_pkg::*;

   logic       valid_ff, valid_in;
   logic       second_ff, second_in;   // first result of the head job already sent
   result_type res_ff, res;
   logic       first_pending;
   logic       load;

   assign first_pending = head_job.has_item && !second_ff;
   assign load          = head_valid && (!valid_ff || rsp_chan.ready);
   assign pop           = load && !(first_pending && head_job.has_status);

   // Result selection for the head job
   always_comb begin
      res = '0;
      if (first_pending) begin
         res.last_of_run = !head_job.has_status;
         if (head_job.item_is_desc) begin
            res.kind            = KIND_DESC;
            res.command         = head_job.command;
            res.datagram_index  = head_job.datagram_index;
            res.slave_address   = head_job.slave_address;
            res.data_length     = head_job.data_length;
            res.more_follows    = head_job.more_follows;
            res.working_counter = head_job.working_counter;
            res.datagram_count  = head_job.datagram_count;
         end else begin
            res.kind         = KIND_DATA;
            res.payload_byte = head_job.payload_byte;
         end
      end else begin
         res.kind           = KIND_STATUS;
         res.frame_status   = head_job.frame_status;
         res.datagram_count = head_job.datagram_count;
         res.last_of_run    = 1'b1;
      end
   end

   // Output register control
   always_comb begin
      valid_in  = valid_ff;
      second_in = second_ff;
      if (load) begin
         valid_in  = 1'b1;
         second_in = first_pending && head_job.has_status;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) res_ff <= res;
   end

   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.kind            = res_ff.kind;
   assign rsp_chan.payload_byte    = res_ff.payload_byte;
   assign rsp_chan.command         = res_ff.command;
   assign rsp_chan.datagram_index  = res_ff.datagram_index;
   assign rsp_chan.slave_address   = res_ff.slave_address;
   assign rsp_chan.data_length     = res_ff.data_length;
   assign rsp_chan.more_follows    = res_ff.more_follows;
   assign rsp_chan.working_counter = res_ff.working_counter;
   assign rsp_chan.frame_status    = res_ff.frame_status;
   assign rsp_chan.datagram_count  = res_ff.datagram_count;
   assign rsp_chan.last_of_run     = res_ff.last_of_run;

   // A half-sent job must still be at the head and owe its status result
   a_second_half: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> (head_valid && head_job.has_status && head_job.has_item))
      else $error("split job lost from queue head");

endmodule

/* rtl/ethercat_datagram_parser_unit.sv */
// Top level of the EtherCAT datagram parser.
// A result reaches rsp_chan through the job queue and the output register.
// Throughput: one request byte per cycle while the job queue is not full; a frame-end byte
//   that also carries data or closes a datagram yields two results through the output register.
// A four-entry job queue between parser and output stage absorbs those extra results.
// Reset is synchronous and active high; it restores the registers to 0x88A4 and 1.
`timescale 1ns / 1ps

module ethercat_datagram_parser_unit #(
   parameter int MAX_FRAME_BYTES = ecdp_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   ecdp_req_if.sink                         req_chan,
   ecdp_rsp_if.source                       rsp_chan,
   input  logic                             csr_write_enable,
   input  logic [ecdp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ecdp_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import ecdp_pkg::*;

   logic    push;
   logic    pop;
   logic    full;
   logic    head_valid;
   job_type push_job;
   job_type head_job;

   ecdp_front #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .queue_full       (full),
      .push             (push),
      .push_job         (push_job)
   );

   ecdp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   ecdp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
